FILE: rtl/core/ordered_unique_key_list_top_assert.svh
// Assertion macros for the ordered key list.
`ifndef ORDERED_UNIQUE_KEY_LIST_TOP_ASSERT_SVH
`define ORDERED_UNIQUE_KEY_LIST_TOP_ASSERT_SVH

// Same-cycle implication.
`define OUKL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oukl assertion failed");

// Next-cycle implication.
`define OUKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oukl assertion failed");

`endif

FILE: rtl/core/oukl_pkg.sv
package oukl_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int POS_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP     = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADPOS  = 3'd4;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_WRITE = 2'd1;
  localparam logic [1:0] CELL_SHR   = 2'd2;
  localparam logic [1:0] CELL_SHL   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] data;
  } cell_ctl_t;

endpackage

FILE: rtl/core/oukl_cell.sv
module oukl_cell (
  input  logic                          clk,
  input  logic [oukl_pkg::IDX_W-1:0]    cell_idx,
  input  logic [oukl_pkg::CNT_W-1:0]    count,
  input  logic [oukl_pkg::KEY_W-1:0]    key,
  input  oukl_pkg::cell_ctl_t           ctl,
  input  logic [oukl_pkg::KEY_W-1:0]    prev_val,
  input  logic [oukl_pkg::KEY_W-1:0]    next_val,
  output logic [oukl_pkg::KEY_W-1:0]    val,
  output logic                          match
);

  logic [oukl_pkg::KEY_W-1:0] val_r;
  logic [oukl_pkg::KEY_W-1:0] val_nxt;
  logic                       in_use;

  assign in_use = {1'b0, cell_idx} < count;
  assign match  = in_use && (val_r == key);
  assign val    = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      oukl_pkg::CELL_WRITE: begin
        if (cell_idx == ctl.idx) val_nxt = ctl.data;
      end
      oukl_pkg::CELL_SHR: begin
        if (cell_idx > ctl.idx) val_nxt = prev_val;
        else if (cell_idx == ctl.idx) val_nxt = ctl.data;
      end
      oukl_pkg::CELL_SHL: begin
        if (cell_idx >= ctl.idx) val_nxt = next_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: rtl/core/oukl_prio.sv
module oukl_prio (
  input  logic [oukl_pkg::DEPTH-1:0]  match,
  output logic [oukl_pkg::CNT_W-1:0]  hit_pos
);

  // one-based position of the lowest set bit, 0 if none
  always_comb begin
    hit_pos = '0;
    for (int i = oukl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) hit_pos = oukl_pkg::CNT_W'(i + 1);
    end
  end

endmodule

FILE: rtl/core/ordered_unique_key_list_top.sv
// Channel Transfer when   Ports
// input   start && !busy  in_command in_key in_new_value in_position
// result  out_strobe      out_status out_found_position out_entry_value out_entry_count out_last
//
// Add, delete, insert, search, update: the compare state (S_CMP) compares the key in all
// cells and encodes the first match, then the execute state (S_EXEC) applies the shift or
// write and presents the result; busy is low in S_EXEC.
// Dump: one entry per cycle through the read mux, or a single empty result when the list is empty.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// Results appear for one cycle on out_strobe; the receiver cannot stall.
module ordered_unique_key_list_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [oukl_pkg::CMD_W-1:0]        in_command,
  input  logic signed [oukl_pkg::KEY_W-1:0] in_key,
  input  logic signed [oukl_pkg::KEY_W-1:0] in_new_value,
  input  logic [oukl_pkg::POS_W-1:0]        in_position,
  output logic                              out_strobe,
  output logic [oukl_pkg::ST_W-1:0]         out_status,
  output logic [oukl_pkg::POS_W-1:0]        out_found_position,
  output logic signed [oukl_pkg::KEY_W-1:0] out_entry_value,
  output logic [oukl_pkg::POS_W-1:0]        out_entry_count,
  output logic                              out_last
);

  `include "ordered_unique_key_list_top_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  localparam int D = oukl_pkg::DEPTH;

  logic [1:0]                   state_r, state_nxt;
  logic [oukl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [oukl_pkg::CNT_W-1:0]   hit_r;
  logic [oukl_pkg::CMD_W-1:0]   cmd_r;
  logic [oukl_pkg::KEY_W-1:0]   key_r;
  logic [oukl_pkg::KEY_W-1:0]   nv_r;
  logic [oukl_pkg::POS_W-1:0]   pos_r;
  logic [oukl_pkg::IDX_W-1:0]   dump_idx_r;

  logic                         accept;
  logic [oukl_pkg::CNT_W-1:0]   hit_pos;
  logic [D-1:0]                 match;
  logic [oukl_pkg::KEY_W-1:0]   cell_val [D];
  oukl_pkg::cell_ctl_t          ctl;

  logic                         hit_any;
  logic                         full;
  logic                         bad_pos;
  logic [oukl_pkg::IDX_W-1:0]   hit_idx;
  logic [oukl_pkg::CNT_W-1:0]   dump_pos;
  logic                         dump_last;

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      logic [oukl_pkg::KEY_W-1:0] prev_v;
      logic [oukl_pkg::KEY_W-1:0] next_v;
      if (g == 0) begin : g_first
        assign prev_v = '0;
      end else begin : g_prev
        assign prev_v = cell_val[g-1];
      end
      if (g == D - 1) begin : g_last
        assign next_v = '0;
      end else begin : g_next
        assign next_v = cell_val[g+1];
      end
      oukl_cell u_cell (
        .clk      (clk),
        .cell_idx (oukl_pkg::IDX_W'(g)),
        .count    (count_r),
        .key      (key_r),
        .ctl      (ctl),
        .prev_val (prev_v),
        .next_val (next_v),
        .val      (cell_val[g]),
        .match    (match[g])
      );
    end
  endgenerate

  oukl_prio u_prio (
    .match   (match),
    .hit_pos (hit_pos)
  );

  assign hit_any   = hit_r != '0;
  assign full      = count_r == oukl_pkg::CNT_W'(D);
  assign bad_pos   = (pos_r == '0) ||
                     ({1'b0, pos_r} > ({1'b0, oukl_pkg::POS_W'(count_r)} + 8'd1));
  assign hit_idx   = oukl_pkg::IDX_W'(hit_r - oukl_pkg::CNT_W'(1));
  assign dump_pos  = oukl_pkg::CNT_W'({1'b0, dump_idx_r}) + oukl_pkg::CNT_W'(1);
  assign dump_last = (count_r == '0) || (dump_pos == count_r);

  assign busy   = (state_r == S_CMP) || ((state_r == S_DUMP) && !dump_last);
  assign accept = start && !busy;

  always_comb begin
    ctl                = '0;
    ctl.op             = oukl_pkg::CELL_HOLD;
    count_nxt          = count_r;
    out_strobe         = 1'b0;
    out_status         = oukl_pkg::ST_OK;
    out_found_position = '0;
    out_entry_value    = '0;
    out_last           = 1'b0;
    if (state_r == S_EXEC) begin
      out_strobe = 1'b1;
      out_last   = 1'b1;
      unique case (cmd_r)
        oukl_pkg::CMD_ADD: begin
          if (hit_any) begin
            out_status         = oukl_pkg::ST_DUP;
            out_found_position = oukl_pkg::POS_W'(hit_r);
          end else if (full) begin
            out_status = oukl_pkg::ST_FULL;
          end else begin
            ctl.op             = oukl_pkg::CELL_WRITE;
            ctl.idx            = oukl_pkg::IDX_W'(count_r);
            ctl.data           = key_r;
            count_nxt          = count_r + oukl_pkg::CNT_W'(1);
            out_found_position = oukl_pkg::POS_W'(count_nxt);
          end
        end
        oukl_pkg::CMD_DELETE: begin
          if (!hit_any) begin
            out_status = oukl_pkg::ST_MISSING;
          end else begin
            ctl.op             = oukl_pkg::CELL_SHL;
            ctl.idx            = hit_idx;
            count_nxt          = count_r - oukl_pkg::CNT_W'(1);
            out_found_position = oukl_pkg::POS_W'(hit_r);
          end
        end
        oukl_pkg::CMD_INSERT: begin
          if (hit_any) begin
            out_status         = oukl_pkg::ST_DUP;
            out_found_position = oukl_pkg::POS_W'(hit_r);
          end else if (full) begin
            out_status = oukl_pkg::ST_FULL;
          end else if (bad_pos) begin
            out_status = oukl_pkg::ST_BADPOS;
          end else begin
            ctl.op             = oukl_pkg::CELL_SHR;
            ctl.idx            = oukl_pkg::IDX_W'(pos_r - oukl_pkg::POS_W'(1));
            ctl.data           = key_r;
            count_nxt          = count_r + oukl_pkg::CNT_W'(1);
            out_found_position = pos_r;
          end
        end
        oukl_pkg::CMD_SEARCH: begin
          out_status         = hit_any ? oukl_pkg::ST_OK : oukl_pkg::ST_MISSING;
          out_found_position = oukl_pkg::POS_W'(hit_r);
        end
        oukl_pkg::CMD_UPDATE: begin
          if (!hit_any) begin
            out_status = oukl_pkg::ST_MISSING;
          end else begin
            ctl.op             = oukl_pkg::CELL_WRITE;
            ctl.idx            = hit_idx;
            ctl.data           = nv_r;
            out_found_position = oukl_pkg::POS_W'(hit_r);
          end
        end
        default: ;
      endcase
    end else if (state_r == S_DUMP) begin
      out_strobe = 1'b1;
      out_last   = dump_last;
      if (count_r != '0) begin
        out_found_position = oukl_pkg::POS_W'(dump_pos);
        out_entry_value    = cell_val[dump_idx_r];
      end
    end
  end

  assign out_entry_count = oukl_pkg::POS_W'(count_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: ;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      S_DUMP: if (dump_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (accept) state_nxt = (in_command == oukl_pkg::CMD_DUMP) ? S_DUMP : S_CMP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      dump_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (accept) dump_idx_r <= '0;
      else if (state_r == S_DUMP) dump_idx_r <= dump_idx_r + oukl_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      key_r <= in_key;
      nv_r  <= in_new_value;
      pos_r <= in_position;
    end
    if (state_r == S_CMP) hit_r <= hit_pos;
  end

  `OUKL_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= oukl_pkg::CNT_W'(D))
  `OUKL_ASSERT_NEXT(a_cmd_no_early_result, clk, rst_n,
    accept && (in_command != oukl_pkg::CMD_DUMP), !out_strobe)
  `OUKL_ASSERT_NEXT(a_add_grows, clk, rst_n,
    (state_r == S_EXEC) && (cmd_r == oukl_pkg::CMD_ADD) && (out_status == oukl_pkg::ST_OK),
    count_r == $past(count_r) + oukl_pkg::CNT_W'(1))
  `OUKL_ASSERT_NOW(a_last_strobed, clk, rst_n, out_last, out_strobe)
  `OUKL_ASSERT_NOW(a_busy_no_accept_in_cmp, clk, rst_n, state_r == S_CMP, busy && !out_strobe)

endmodule

FILE: bench/ordered_unique_key_list_top_test.sv
module ordered_unique_key_list_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import oukl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 80;
  localparam int HOT_KEYS = 24;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] new_value;
    logic [POS_W-1:0]        position;
    bit                      drain;
    bit                      calm;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        found_position;
    logic signed [KEY_W-1:0] entry_value;
    logic [POS_W-1:0]        entry_count;
    logic                    last;
  } list_reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_command = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic signed [KEY_W-1:0] in_new_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_strobe;
  logic [ST_W-1:0]         out_status;
  logic [POS_W-1:0]        out_found_position;
  logic signed [KEY_W-1:0] out_entry_value;
  logic [POS_W-1:0]        out_entry_count;
  logic                    out_last;

  list_cmd_t   cmd_q[$];
  list_reply_t reply_q[$];
  list_cmd_t   cur_cmd;

  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int shadow_count = 0;
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  int error_count = 0;
  int cycle_count = 0;
  int idle_left = 0;
  int cmds_done = 0;
  int replies_seen = 0;
  int peak_count = 0;
  int full_rejects = 0;
  int dump_entries = 0;

  ordered_unique_key_list_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_key(in_key),
    .in_new_value(in_new_value),
    .in_position(in_position),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_found_position(out_found_position),
    .out_entry_value(out_entry_value),
    .out_entry_count(out_entry_count),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic push_reply(input logic [ST_W-1:0] status, input int pos,
                            input logic signed [KEY_W-1:0] value, input bit last);
    list_reply_t r;
    r.status = status;
    r.found_position = POS_W'(pos);
    r.entry_value = value;
    r.entry_count = POS_W'(shadow_count);
    r.last = last;
    reply_q.push_back(r);
  endtask

  // Updates the shadow list for one command and queues its replies.
  task automatic apply_list_cmd(input list_cmd_t c);
    int hit;
    int i;
    hit = 0;
    for (i = 0; i < shadow_count; i++)
      if (hit == 0 && shadow_keys[i] == c.key) hit = i + 1;
    case (c.cmd)
      CMD_ADD: begin
        if (hit != 0) begin
          push_reply(ST_DUP, hit, '0, 1'b1);
        end else if (shadow_count >= DEPTH) begin
          full_rejects++;
          push_reply(ST_FULL, 0, '0, 1'b1);
        end else begin
          shadow_keys[shadow_count] = c.key;
          shadow_count++;
          push_reply(ST_OK, shadow_count, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (hit == 0) begin
          push_reply(ST_MISSING, 0, '0, 1'b1);
        end else begin
          for (i = hit - 1; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count--;
          push_reply(ST_OK, hit, '0, 1'b1);
        end
      end
      CMD_INSERT: begin
        if (hit != 0) begin
          push_reply(ST_DUP, hit, '0, 1'b1);
        end else if (shadow_count >= DEPTH) begin
          full_rejects++;
          push_reply(ST_FULL, 0, '0, 1'b1);
        end else if (c.position == 0 || int'(c.position) > shadow_count + 1) begin
          push_reply(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (i = shadow_count; i >= int'(c.position); i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[c.position - 1] = c.key;
          shadow_count++;
          push_reply(ST_OK, int'(c.position), '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        push_reply((hit != 0) ? ST_OK : ST_MISSING, hit, '0, 1'b1);
      end
      CMD_UPDATE: begin
        if (hit == 0) begin
          push_reply(ST_MISSING, 0, '0, 1'b1);
        end else begin
          shadow_keys[hit - 1] = c.new_value;
          push_reply(ST_OK, hit, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (shadow_count == 0) begin
          push_reply(ST_OK, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            push_reply(ST_OK, i + 1, shadow_keys[i], (i + 1 == shadow_count));
          dump_entries += shadow_count;
        end
      end
      default: begin
        push_reply(ST_OK, 0, '0, 1'b1);
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  task automatic check_field(input string name, input logic [KEY_W-1:0] expv,
                             input logic [KEY_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      error_count++;
    end
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key,
                           input logic signed [KEY_W-1:0] new_value,
                           input logic [POS_W-1:0] position, input bit drain, input bit calm);
    list_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.new_value = new_value;
    c.position = position;
    c.drain = drain;
    c.calm = calm;
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, HOT_KEYS - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return POS_W'($urandom_range(1, 24));
    if (r < 9) return POS_W'($urandom_range(1, 65));
    return POS_W'($urandom);
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        apply_list_cmd(cur_cmd);
        cmds_done++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (cmd_q.size() == 0 ||
                     (cmd_q[0].drain && (reply_q.size() != 0 || out_strobe || start))) begin
          start <= 1'b0;
        end else if (!cmd_q[0].calm && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(0, 6);
          start <= 1'b0;
          in_command <= CMD_W'($urandom);
          in_key <= $urandom;
          in_new_value <= $urandom;
          in_position <= POS_W'($urandom);
        end else begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          in_command <= cur_cmd.cmd;
          in_key <= cur_cmd.key;
          in_new_value <= cur_cmd.new_value;
          in_position <= cur_cmd.position;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    list_reply_t r;
    if (rst_n && out_strobe) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        error_count++;
      end else begin
        r = reply_q.pop_front();
        check_field("status", KEY_W'(r.status), KEY_W'(out_status));
        check_field("found_position", KEY_W'(r.found_position), KEY_W'(out_found_position));
        check_field("entry_value", r.entry_value, out_entry_value);
        check_field("entry_count", KEY_W'(r.entry_count), KEY_W'(out_entry_count));
        check_field("last", KEY_W'(r.last), KEY_W'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    int sel;
    bit calm;
    bit drain;
    logic signed [KEY_W-1:0] kmin;
    logic signed [KEY_W-1:0] kmax;
    kmin = 32'h8000_0000;
    kmax = 32'h7fff_ffff;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;

    // directed: empty list, bad positions, extremes, first-match rules
    queue_cmd(CMD_DUMP, 0, 0, 1, 0, 0);
    queue_cmd(CMD_SEARCH, 5, 0, 1, 0, 0);
    queue_cmd(CMD_DELETE, 5, 0, 1, 0, 0);
    queue_cmd(CMD_UPDATE, 5, 9, 1, 0, 0);
    queue_cmd(CMD_INSERT, 1, 0, 0, 0, 0);
    queue_cmd(CMD_INSERT, 1, 0, 2, 0, 0);
    queue_cmd(CMD_INSERT, kmin, 0, 1, 0, 0);
    queue_cmd(CMD_ADD, kmax, 0, 1, 0, 0);
    queue_cmd(CMD_ADD, kmin, 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, kmax, 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, 0, 0, 2, 0, 0);
    queue_cmd(CMD_INSERT, -1, 0, 4, 0, 0);
    queue_cmd(CMD_SEARCH, 0, 0, 1, 0, 0);
    queue_cmd(CMD_UPDATE, 0, kmax, 1, 0, 0);
    queue_cmd(CMD_SEARCH, kmax, 0, 1, 0, 0);
    queue_cmd(CMD_DUMP, 0, 0, 1, 0, 0);
    queue_cmd(CMD_DELETE, kmin, 0, 1, 0, 0);
    queue_cmd(CMD_DELETE, -1, 0, 1, 0, 0);
    queue_cmd(CMD_DELETE, kmax, 0, 1, 0, 0);
    queue_cmd(CMD_SPARE_LO, kmax, kmin, 7'h7f, 0, 0);
    queue_cmd(CMD_SPARE_HI, kmin, kmax, 7'h40, 0, 0);
    queue_cmd(CMD_INSERT, 3, 0, 7'h7f, 0, 0);
    queue_cmd(CMD_UPDATE, kmax, 32'h5555_5555, 1, 0, 0);
    queue_cmd(CMD_DUMP, 0, 0, 1, 0, 0);

    // fill to capacity, then probe full, duplicate and edge positions
    for (n = 0; n < POOL_SIZE; n++) queue_cmd(CMD_ADD, key_pool[n], 0, 1, (n == 0), 0);
    queue_cmd(CMD_ADD, $urandom, 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, $urandom, 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, key_pool[3], 0, 5, 0, 0);
    queue_cmd(CMD_ADD, key_pool[0], 0, 1, 0, 0);
    queue_cmd(CMD_DUMP, 0, 0, 1, 1, 0);
    queue_cmd(CMD_DELETE, key_pool[5], 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, $urandom, 0, 64, 0, 0);
    queue_cmd(CMD_INSERT, $urandom, 0, 65, 0, 0);
    queue_cmd(CMD_DELETE, key_pool[6], 0, 1, 0, 0);
    queue_cmd(CMD_INSERT, $urandom, 0, 65, 0, 0);
    queue_cmd(CMD_SEARCH, key_pool[POOL_SIZE - 1], 0, 1, 0, 0);

    // random mix over a small hot key set so most commands hit
    for (n = 0; n < 250; n++) begin
      sel = $urandom_range(0, 99);
      calm = (n >= 210);
      drain = (n == 120);
      if (sel < 22)
        queue_cmd(CMD_ADD, pick_key(), $urandom, POS_W'($urandom), drain, calm);
      else if (sel < 42)
        queue_cmd(CMD_DELETE, pick_key(), $urandom, POS_W'($urandom), drain, calm);
      else if (sel < 64)
        queue_cmd(CMD_INSERT, pick_key(), $urandom, pick_position(), drain, calm);
      else if (sel < 78)
        queue_cmd(CMD_SEARCH, pick_key(), $urandom, POS_W'($urandom), drain, calm);
      else if (sel < 89)
        queue_cmd(CMD_UPDATE, pick_key(), pick_key(), POS_W'($urandom), drain, calm);
      else if (sel < 97)
        queue_cmd(CMD_DUMP, $urandom, $urandom, POS_W'($urandom), drain, calm);
      else
        queue_cmd($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, $urandom, $urandom,
                  POS_W'($urandom), drain, calm);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (reply_q.size() != 0 || out_strobe) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("commands transferred: %0d, results checked: %0d, dump entries: %0d",
             cmds_done, replies_seen, dump_entries);
    $display("peak list size: %0d, full-list rejects: %0d", peak_count, full_rejects);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/oukl_pkg.sv
rtl/core/oukl_cell.sv
rtl/core/oukl_prio.sv
rtl/core/ordered_unique_key_list_top.sv
bench/ordered_unique_key_list_top_test.sv
